// ----- design/wfd_pkg.sv -----
// Package for the WebSocket frame deframer.
// Holds the status codes, the result type and the reset value of the size limit.
// No dependencies.
package wfd_pkg;

    localparam logic [3:0] ST_PROGRESS   = 4'd0;
    localparam logic [3:0] ST_MESSAGE    = 4'd1;
    localparam logic [3:0] ST_PING       = 4'd2;
    localparam logic [3:0] ST_PONG       = 4'd3;
    localparam logic [3:0] ST_CLOSE      = 4'd4;
    localparam logic [3:0] ST_NOMASK     = 4'd5;
    localparam logic [3:0] ST_RSV        = 4'd6;
    localparam logic [3:0] ST_BADCONTROL = 4'd7;
    localparam logic [3:0] ST_BADOP      = 4'd8;
    localparam logic [3:0] ST_TOOBIG     = 4'd9;
    localparam logic [3:0] ST_CONT       = 4'd10;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16384;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [3:0] frame_opcode;
        logic       last;
        logic [3:0] status;
    } wfd_res_t;

endpackage

// ----- design/wfd_in_stage.sv -----
// Input register of the WebSocket frame deframer.
// Holds one received byte until the parser takes it.
// Depends on nothing beyond the clock and reset.
module wfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;

    assign rx_ready   = !vld_reg || take;
    assign vld_next   = rx_ready ? rx_valid : 1'b1;
    assign held_valid = vld_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ----- design/wfd_parser.sv -----
// Frame parser and unmasker of the WebSocket frame deframer.
// Holds the per-frame state and forms at most one result for each byte.
// Depends on wfd_pkg.
module wfd_parser
    import wfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] max_payload,
    output logic        res_fire,
    output wfd_res_t    res
);

    localparam logic [2:0] PH_HEAD0   = 3'd0;
    localparam logic [2:0] PH_HEAD1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  head_reg,    head_next;
    logic [63:0] length_reg,  length_next;
    logic [3:0]  ext_reg,     ext_next;
    logic [31:0] key_reg,     key_next;
    logic [31:0] index_reg,   index_next;
    logic        halted_reg,  halted_next;

    logic [3:0]  op;
    logic [6:0]  len7;
    logic [32:0] index_inc;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic        emits;
    logic        hdr_err;
    logic [3:0]  hdr_code;

    function automatic logic [3:0] disposition(input logic [3:0] opc);
        case (opc)
            OP_TEXT, OP_BIN: disposition = ST_MESSAGE;
            OP_PING:         disposition = ST_PING;
            OP_PONG:         disposition = ST_PONG;
            OP_CLOSE:        disposition = ST_CLOSE;
            default:         disposition = ST_CONT;
        endcase
    endfunction

    assign op        = head_reg[3:0];
    assign len7      = rx_byte[6:0];
    assign index_inc = {1'b0, index_reg} + 33'd1;
    assign emits     = (op == OP_TEXT) || (op == OP_BIN) || (op == OP_PING);
    assign plain     = rx_byte ^ key_byte;

    always_comb
    begin
        case (index_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        hdr_err  = 1'b1;
        hdr_code = ST_PROGRESS;
        if (!rx_byte[7])
        begin
            hdr_code = ST_NOMASK;
        end
        else if (head_reg[6:4] != 3'd0)
        begin
            hdr_code = ST_RSV;
        end
        else if (op inside {OP_CLOSE, OP_PING, OP_PONG})
        begin
            if ((len7 > 7'd125) || !head_reg[7])
            begin
                hdr_code = ST_BADCONTROL;
            end
            else
            begin
                hdr_err = 1'b0;
            end
        end
        else if (op > OP_BIN)
        begin
            hdr_code = ST_BADOP;
        end
        else
        begin
            hdr_err = 1'b0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        head_next   = head_reg;
        length_next = length_reg;
        ext_next    = ext_reg;
        key_next    = key_reg;
        index_next  = index_reg;
        halted_next = halted_reg;
        res_fire    = 1'b0;
        res         = '{out_byte: 8'd0, out_valid: 1'b0, frame_opcode: op,
                        last: 1'b0, status: ST_PROGRESS};
        if (go && !halted_reg)
        begin
            case (phase_reg)
                PH_HEAD0:
                begin
                    head_next  = rx_byte;
                    phase_next = PH_HEAD1;
                end
                PH_HEAD1:
                begin
                    if (hdr_err)
                    begin
                        res_fire    = 1'b1;
                        res.last    = 1'b1;
                        res.status  = hdr_code;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        key_next   = 32'd0;
                        index_next = 32'd0;
                        if (len7 == 7'd126)
                        begin
                            length_next = 64'd0;
                            ext_next    = 4'd2;
                            phase_next  = PH_EXTLEN;
                        end
                        else if (len7 == 7'd127)
                        begin
                            length_next = 64'd0;
                            ext_next    = 4'd8;
                            phase_next  = PH_EXTLEN;
                        end
                        else
                        begin
                            length_next = {57'd0, len7};
                            ext_next    = 4'd0;
                            phase_next  = PH_MASK;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    length_next = {length_reg[55:0], rx_byte};
                    ext_next    = ext_reg - 4'd1;
                    if (ext_reg == 4'd1)
                    begin
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK:
                begin
                    key_next   = {key_reg[23:0], rx_byte};
                    index_next = index_inc[31:0];
                    if (index_reg[1:0] == 2'd3)
                    begin
                        index_next = 32'd0;
                        if (length_reg > {32'd0, max_payload})
                        begin
                            res_fire    = 1'b1;
                            res.last    = 1'b1;
                            res.status  = ST_TOOBIG;
                            halted_next = 1'b1;
                        end
                        else if (length_reg == 64'd0)
                        begin
                            res_fire   = 1'b1;
                            res.last   = 1'b1;
                            res.status = disposition(op);
                            phase_next = PH_HEAD0;
                            if ((res.status == ST_CLOSE) || (res.status == ST_CONT))
                            begin
                                halted_next = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    index_next = index_inc[31:0];
                    if ({31'd0, index_inc} >= length_reg)
                    begin
                        res_fire      = 1'b1;
                        res.last      = 1'b1;
                        res.out_byte  = emits ? plain : 8'd0;
                        res.out_valid = emits;
                        res.status    = disposition(op);
                        phase_next    = PH_HEAD0;
                        if ((res.status == ST_CLOSE) || (res.status == ST_CONT))
                        begin
                            halted_next = 1'b1;
                        end
                    end
                    else if (emits)
                    begin
                        res_fire      = 1'b1;
                        res.out_byte  = plain;
                        res.out_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD0;
            head_reg   <= 8'd0;
            length_reg <= 64'd0;
            ext_reg    <= 4'd0;
            key_reg    <= 32'd0;
            index_reg  <= 32'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            head_reg   <= head_next;
            length_reg <= length_next;
            ext_reg    <= ext_next;
            key_reg    <= key_next;
            index_reg  <= index_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ----- design/wfd_res_stage.sv -----
// Result register of the WebSocket frame deframer.
// Holds one result request until the consumer takes it.
// Depends on wfd_pkg.
module wfd_res_stage
    import wfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  wfd_res_t res_in,
    input  logic     res_ready,
    output logic     res_valid,
    output wfd_res_t res_out
);

    logic     vld_reg;
    logic     vld_next;
    wfd_res_t data_reg;

    assign vld_next  = load ? 1'b1 : (vld_reg && !res_ready);
    assign res_valid = vld_reg;
    assign res_out   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wfd_pkg, wfd_in_stage, wfd_parser and wfd_res_stage.
//
// Takes one received client-to-server byte per cycle while res_ready stays high, and
// delivers unmasked payload bytes of text, binary and ping frames, plus one last-marked
// result per frame with its disposition. Each byte passes through the input register
// and the parser's combinational logic into the result register; the parser takes a
// byte from the input register only while the result register is empty or being read.
// While a result waits in the result register and res_ready is low, rx_ready drops
// once the input register is also full. After an error, a close frame or a
// continuation frame, all bytes are dropped until reset. max_payload may be written
// only while no bytes are in flight.
module websocket_frame_deframer
    import wfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic [3:0]  frame_opcode,
    output logic        last,
    output logic [3:0]  status
);

    logic [31:0] max_payload_reg;
    logic        held_valid;
    logic [7:0]  held_byte;
    logic        take;
    logic        res_fire;
    wfd_res_t    res_new;
    wfd_res_t    res_cur;

    assign take = held_valid && (!res_valid || res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    wfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (take),
        .rx_byte     (held_byte),
        .max_payload (max_payload_reg),
        .res_fire    (res_fire),
        .res         (res_new)
    );

    wfd_res_stage u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .res_in    (res_new),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_out   (res_cur)
    );

    assign out_byte     = res_cur.out_byte;
    assign out_valid    = res_cur.out_valid;
    assign frame_opcode = res_cur.frame_opcode;
    assign last         = res_cur.last;
    assign status       = res_cur.status;

endmodule

// ----- design/wfd_checker.sv -----
// Port-level checker for the WebSocket frame deframer, with its bind statement.
// Depends on wfd_pkg and the ports of websocket_frame_deframer.
module wfd_checker
    import wfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       last,
    input logic [3:0] status
);

    a_last_has_disposition: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last) |-> (status != ST_PROGRESS))
        else $error("final result carries in-progress status");

    a_mid_is_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |-> (status == ST_PROGRESS && out_valid))
        else $error("non-final result without payload byte or with a disposition");

    a_no_byte_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (out_byte == 8'd0))
        else $error("empty result carries a nonzero byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(out_byte) && $stable(status)))
        else $error("stalled result request changed");

endmodule

bind websocket_frame_deframer wfd_checker u_wfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .last      (last),
    .status    (status)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer: drives framed client bytes and
// checks every result against a byte-level parser predictor or a typed directed row.
// Depends on wfd_pkg and the deframer RTL.
module tb_top;
    import wfd_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_HDR0,
        AWAIT_HDR1,
        READ_EXTLEN,
        READ_KEY,
        READ_PAYLOAD
    } rx_phase_t;

    typedef enum {LEN7, LEN16, LEN64} len_form_t;

    typedef enum {
        END_NOMASK,
        END_RSV,
        END_BADCTL,
        END_BADOP,
        END_TOOBIG,
        END_CONT,
        END_CLOSE,
        END_NOISE
    } ending_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        wfd_res_t   res;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [28] = '{
        '{8'h81, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 1'b0, OP_TEXT, 1'b1, ST_MESSAGE}},
        '{8'h89, 1'b0, '0},
        '{8'h81, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'h00, 1'b1, OP_PING, 1'b1, ST_PING}},
        '{8'h02, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h34, 1'b0, '0},
        '{8'h56, 1'b0, '0},
        '{8'h78, 1'b0, '0},
        '{8'hA5, 1'b0, '0},
        '{8'h8A, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'h00, 1'b0, OP_PONG, 1'b1, ST_PONG}}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte   = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [3:0]  frame_opcode;
    logic        last;
    logic [3:0]  status;

    rx_phase_t   parse_phase     = AWAIT_HDR0;
    logic [7:0]  hdr0            = '0;
    logic [63:0] frame_len       = '0;
    logic [3:0]  ext_left        = '0;
    logic [31:0] mask_key        = '0;
    logic [63:0] byte_pos        = '0;
    logic        stream_halted   = 1'b0;
    logic [31:0] max_payload_cfg = MAX_PAYLOAD_RESET;

    wfd_res_t    expected_results [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          calm       = 1'b0;
    bit          bursty     = 1'b1;

    websocket_frame_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .frame_opcode (frame_opcode),
        .last         (last),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic wfd_res_t frame_res(logic [7:0] ob, logic ov, logic lst, logic [3:0] st);
        wfd_res_t r;
        r.out_byte     = ob;
        r.out_valid    = ov;
        r.frame_opcode = hdr0[3:0];
        r.last         = lst;
        r.status       = st;
        return r;
    endfunction

    task automatic deframe_step(input logic [7:0] b, output logic produced,
                                output wfd_res_t res);
        logic [3:0] op;
        logic [6:0] len7;
        logic [7:0] ub;
        logic       emit;
        logic       ctrl;
        logic       frame_done;
        logic [7:0] done_byte;
        logic [3:0] err;
        logic [3:0] fin_st;
        produced   = 1'b0;
        res        = '0;
        frame_done = 1'b0;
        done_byte  = 8'h00;
        err        = ST_PROGRESS;
        if (stream_halted)
            return;
        op   = hdr0[3:0];
        emit = (op == OP_TEXT) || (op == OP_BIN) || (op == OP_PING);
        ctrl = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
        case (op)
            OP_TEXT, OP_BIN: fin_st = ST_MESSAGE;
            OP_PING:         fin_st = ST_PING;
            OP_PONG:         fin_st = ST_PONG;
            OP_CLOSE:        fin_st = ST_CLOSE;
            default:         fin_st = ST_CONT;
        endcase
        case (parse_phase)
            AWAIT_HDR0:
            begin
                hdr0        = b;
                parse_phase = AWAIT_HDR1;
            end
            AWAIT_HDR1:
            begin
                len7 = b[6:0];
                if (!b[7])
                    err = ST_NOMASK;
                else if (hdr0[6:4] != 3'b000)
                    err = ST_RSV;
                else if (ctrl && (len7 > 7'd125 || !hdr0[7]))
                    err = ST_BADCONTROL;
                else if (!ctrl && op > OP_BIN)
                    err = ST_BADOP;
                if (err == ST_PROGRESS)
                begin
                    frame_len = '0;
                    mask_key  = '0;
                    byte_pos  = '0;
                    if (len7 == 7'd126)
                    begin
                        ext_left    = 4'd2;
                        parse_phase = READ_EXTLEN;
                    end
                    else if (len7 == 7'd127)
                    begin
                        ext_left    = 4'd8;
                        parse_phase = READ_EXTLEN;
                    end
                    else
                    begin
                        frame_len   = {57'd0, len7};
                        ext_left    = 4'd0;
                        parse_phase = READ_KEY;
                    end
                end
            end
            READ_EXTLEN:
            begin
                frame_len = {frame_len[55:0], b};
                ext_left--;
                if (ext_left == 4'd0)
                    parse_phase = READ_KEY;
            end
            READ_KEY:
            begin
                mask_key = {mask_key[23:0], b};
                byte_pos++;
                if (byte_pos == 64'd4)
                begin
                    byte_pos = '0;
                    if (frame_len > {32'd0, max_payload_cfg})
                        err = ST_TOOBIG;
                    else if (frame_len == 64'd0)
                        frame_done = 1'b1;
                    else
                        parse_phase = READ_PAYLOAD;
                end
            end
            default:
            begin
                ub = b ^ mask_key[8 * (3 - int'(byte_pos[1:0])) +: 8];
                byte_pos++;
                if (byte_pos >= frame_len)
                begin
                    frame_done = 1'b1;
                    done_byte  = emit ? ub : 8'h00;
                end
                else if (emit)
                begin
                    produced = 1'b1;
                    res      = frame_res(ub, 1'b1, 1'b0, ST_PROGRESS);
                end
            end
        endcase
        if (err != ST_PROGRESS)
        begin
            produced      = 1'b1;
            res           = frame_res(8'h00, 1'b0, 1'b1, err);
            stream_halted = 1'b1;
        end
        else if (frame_done)
        begin
            produced    = 1'b1;
            res         = frame_res(done_byte, emit && (frame_len != 0), 1'b1, fin_st);
            parse_phase = AWAIT_HDR0;
            if (fin_st == ST_CLOSE || fin_st == ST_CONT)
                stream_halted = 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input wfd_res_t typed_res = '0);
        logic     produced;
        wfd_res_t predicted;
        if (!calm && bursty && $urandom_range(0, 5) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        bytes_sent++;
        deframe_step(b, produced, predicted);
        if (typed)
            expected_results.push_back(typed_res);
        else if (produced)
            expected_results.push_back(predicted);
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                              input len_form_t form, input logic header_only);
        logic [31:0] key;
        key    = $urandom();
        bursty = ($urandom_range(0, 3) != 0);
        send_byte({fin, 3'b000, op});
        case (form)
            LEN7:
                send_byte({1'b1, len[6:0]});
            LEN16:
            begin
                send_byte(8'hFE);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte(8'hFF);
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(key[8 * i +: 8]);
        if (!header_only)
            for (longint unsigned n = 0; n < len; n++)
                send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic write_max(input logic [31:0] v);
        rx_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we          <= 1'b0;
        max_payload_cfg = v;
    endtask

    function automatic logic [63:0] pick_len(int unsigned cap);
        int unsigned short_cap;
        short_cap = (cap < 40) ? cap : 40;
        if ($urandom_range(0, 4) != 0)
            return 64'($urandom_range(0, short_cap));
        return 64'($urandom_range(0, cap));
    endfunction

    function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        wfd_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, actual byte %0h valid %0b op %0h last %0b st %0d",
                         $time, out_byte, out_valid, frame_opcode, last, status);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_byte", want.out_byte, out_byte);
                check_field("out_valid", want.out_valid, out_valid);
                check_field("frame_opcode", want.frame_opcode, frame_opcode);
                check_field("last", want.last, last);
                check_field("status", want.status, status);
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    initial
    begin
        logic [31:0] lim;
        logic [63:0] len;
        logic [3:0]  op;
        logic [7:0]  h;
        logic        fin;
        len_form_t   form;
        ending_t     ending;
        int unsigned cap;
        int          sel;
        int          r;
        int          start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:       lim = 32'd0;
                1:       lim = 32'hFFFF_FFFF;
                2:       lim = $urandom_range(1, 16);
                default: lim = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 600) : $urandom();
            endcase
            write_max(lim);
            if (p == 6)
                calm = 1'b1;
            cap   = (max_payload_cfg > 300) ? 300 : max_payload_cfg;
            start = bytes_sent;
            while (bytes_sent - start < 70)
            begin
                sel = $urandom_range(0, 9);
                if (sel >= 7)
                begin
                    op  = (sel == 9) ? OP_PONG : OP_PING;
                    len = pick_len((cap < 125) ? cap : 125);
                    send_frame(1'b1, op, len, LEN7, 1'b0);
                end
                else
                begin
                    op  = (sel < 4) ? OP_TEXT : OP_BIN;
                    len = pick_len(cap);
                    r   = $urandom_range(0, 9);
                    if (len < 126)
                        form = (r < 7) ? LEN7 : ((r < 9) ? LEN16 : LEN64);
                    else
                        form = (r < 8) ? LEN16 : LEN64;
                    fin = 1'($urandom_range(0, 1));
                    send_frame(fin, op, len, form, 1'b0);
                end
            end
        end

        ending = ending_t'($urandom_range(0, 7));
        fin    = 1'($urandom_range(0, 1));
        case (ending)
            END_NOMASK:
            begin
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 127)));
            end
            END_RSV:
            begin
                h = 8'($urandom_range(0, 255));
                if (h[6:4] == 3'b000)
                    h[4 + $urandom_range(0, 2)] = 1'b1;
                send_byte(h);
                send_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            END_BADCTL:
            begin
                r  = $urandom_range(0, 2);
                op = (r == 0) ? OP_CLOSE : ((r == 1) ? OP_PING : OP_PONG);
                send_byte({fin, 3'b000, op});
                if (fin)
                    send_byte({1'b1, 7'($urandom_range(126, 127))});
                else
                    send_byte({1'b1, 7'($urandom_range(0, 127))});
            end
            END_BADOP:
            begin
                r  = $urandom_range(0, 9);
                op = (r < 5) ? 4'(3 + r) : 4'(6 + r);
                send_byte({fin, 3'b000, op});
                send_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            END_TOOBIG:
            begin
                if (max_payload_cfg == 32'hFFFF_FFFF)
                begin
                    len = {$urandom(), $urandom()};
                    if (len[63:32] == 32'd0)
                        len[32] = 1'b1;
                    form = LEN64;
                end
                else
                begin
                    len  = {32'd0, max_payload_cfg} + 64'd1 + 64'($urandom_range(0, 1000));
                    form = (len > 65535) ? LEN64 : ((len > 125) ? LEN16 : LEN7);
                    if ($urandom_range(0, 1) != 0)
                        form = LEN64;
                    if (form == LEN64 && $urandom_range(0, 1) != 0)
                        len[63] = 1'b1;
                end
                send_frame(fin, 4'($urandom_range(0, 2)), len, form, 1'b1);
            end
            END_CONT:
            begin
                cap = (max_payload_cfg > 20) ? 20 : max_payload_cfg;
                send_frame(fin, OP_CONT, 64'($urandom_range(0, cap)), LEN7, 1'b0);
            end
            END_CLOSE:
            begin
                cap = (max_payload_cfg > 20) ? 20 : max_payload_cfg;
                send_frame(1'b1, OP_CLOSE, 64'($urandom_range(0, cap)), LEN7, 1'b0);
            end
            default:
                repeat (40) send_byte(8'($urandom_range(0, 255)));
        endcase
        repeat (12) send_byte(8'($urandom_range(0, 255)));

        rx_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
design/wfd_pkg.sv
design/wfd_in_stage.sv
design/wfd_parser.sv
design/wfd_res_stage.sv
design/websocket_frame_deframer.sv
design/wfd_checker.sv
verif/tb_top.sv
